// File: sv/psal_pkg.sv
// ----------------------------------------------------------------------------
// psal_pkg
// Widths, fixed-point constants and the queue item type shared by the
// practical salinity datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package psal_pkg;

    // field widths
    localparam int COND_W = 24;
    localparam int TEMP_W = 15;
    localparam int SAL_W  = 32;
    localparam int REF_W  = 32;

    // internal widths
    localparam int Q_W      = 40;   // first ratio, Q32, clamped to 128
    localparam int RT_W     = 25;   // rt polynomial, Q24
    localparam int FNUM_W   = 61;   // factor dividend
    localparam int FDEN_W   = 33;   // factor divisor
    localparam int RQ_W     = 39;   // ratio after rt, Q32, clamped to 64
    localparam int X_W      = 24;   // square root, Q20
    localparam int F_W      = 30;   // temperature factor, Q22
    localparam int RT_ACC_W = 44;   // rt accumulator, Q40
    localparam int P_ACC_W  = 41;   // a and b accumulators, Q22
    localparam int B_W      = 31;   // b value, Q22, magnitude below 256 for x up to 8

    localparam logic [REF_W-1:0]         REF_RESET = 32'd281241190;
    localparam logic signed [TEMP_W-1:0] T_LOW     = -15'sd2560;
    localparam logic signed [TEMP_W-1:0] T_HIGH    = 15'sd12800;
    localparam logic signed [TEMP_W-1:0] T_FIFTEEN = 15'sd3840;
    localparam logic [18:0]              K_DEN     = 19'd271790;
    localparam logic [Q_W-1:0]           Q_MAX     = 40'd549755813888;   // 128 in Q32
    localparam logic [RQ_W-1:0]          R_MAX     = 39'd274877906944;   // 64 in Q32

    // rt coefficients, Q40, lowest power first
    localparam logic signed [RT_ACC_W-1:0] C_RT [5] = '{
        44'((64'sd6766097 * (64'sd1 <<< 40) + 64'sd5000000) / 64'sd10000000),
        44'((64'sd200564 * (64'sd1 <<< 40) + 64'sd5000000) / 64'sd10000000),
        44'((64'sd1104259 * (64'sd1 <<< 40) + 64'sd5000000000) / 64'sd10000000000),
        44'(-((64'sd69698 * (64'sd1 <<< 40) + 64'sd50000000000) / 64'sd100000000000)),
        44'((64'sd10031 * (64'sd1 <<< 40) + 64'sd5000000000000) / 64'sd10000000000000)
    };

    // a polynomial, Q22, lowest power first
    localparam logic signed [P_ACC_W-1:0] C_A [6] = '{
        41'((64'sd8 * (64'sd1 <<< 22) + 64'sd500) / 64'sd1000),
        41'(-((64'sd1692 * (64'sd1 <<< 22) + 64'sd5000) / 64'sd10000)),
        41'((64'sd253851 * (64'sd1 <<< 22) + 64'sd5000) / 64'sd10000),
        41'((64'sd140941 * (64'sd1 <<< 22) + 64'sd5000) / 64'sd10000),
        41'(-((64'sd70261 * (64'sd1 <<< 22) + 64'sd5000) / 64'sd10000)),
        41'((64'sd27081 * (64'sd1 <<< 22) + 64'sd5000) / 64'sd10000)
    };

    // b polynomial, Q22, lowest power first
    localparam logic signed [P_ACC_W-1:0] C_B [6] = '{
        41'((64'sd5 * (64'sd1 <<< 22) + 64'sd5000) / 64'sd10000),
        41'(-((64'sd56 * (64'sd1 <<< 22) + 64'sd5000) / 64'sd10000)),
        41'(-((64'sd66 * (64'sd1 <<< 22) + 64'sd5000) / 64'sd10000)),
        41'(-((64'sd375 * (64'sd1 <<< 22) + 64'sd5000) / 64'sd10000)),
        41'((64'sd636 * (64'sd1 <<< 22) + 64'sd5000) / 64'sd10000),
        41'(-((64'sd144 * (64'sd1 <<< 22) + 64'sd5000) / 64'sd10000))
    };

    // item handed from front to back through the queue
    typedef struct packed {
        logic [Q_W-1:0]    q;
        logic [RT_W-1:0]   rt;
        logic [FNUM_W-1:0] fnum;
        logic [FDEN_W-1:0] fden;
        logic              dneg;
    } front_item_t;

endpackage

`default_nettype wire

// File: sv/psal_div_pipe.sv
// ----------------------------------------------------------------------------
// psal_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with overflow
// flag and a sideband that travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module psal_div_pipe #(
    parameter int NUM_W = 56,
    parameter int DEN_W = 32,
    parameter int QUO_W = 40,
    parameter int SB_W  = 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    input  wire logic [SB_W-1:0]  sb_in,
    output logic      [QUO_W-1:0] quo,
    output logic                  ovf,
    output logic      [SB_W-1:0]  sb_out
);

    localparam int HI_W  = NUM_W - QUO_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [DEN_W-1:0] rem_reg  [QUO_W+1];
    logic [QUO_W-1:0] work_reg [QUO_W+1];
    logic [DEN_W-1:0] den_reg  [QUO_W+1];
    logic             ovf_reg  [QUO_W+1];
    logic [SB_W-1:0]  sb_reg   [QUO_W+1];

    logic [CMP_W-1:0] hi;
    logic [CMP_W-1:0] den_ext;

    // upper dividend part; at or above the divisor means quotient overflow
    assign hi      = CMP_W'(num[NUM_W-1:QUO_W]);
    assign den_ext = CMP_W'(den);

    // entry stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= DEN_W'(hi);
            work_reg[0] <= num[QUO_W-1:0];
            den_reg[0]  <= den;
            ovf_reg[0]  <= (hi >= den_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sb_reg[0] <= '0;
        else if (en)
            sb_reg[0] <= sb_in;
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= QUO_W; k++)
    begin : g_stage
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W:0]   diff;
        logic [DEN_W-1:0] rem_next;
        logic [QUO_W-1:0] work_next;

        always_comb
        begin
            trial     = {rem_reg[k-1], work_reg[k-1][QUO_W-1]};
            ge        = (trial >= {1'b0, den_reg[k-1]});
            diff      = trial - {1'b0, den_reg[k-1]};
            rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            work_next = {work_reg[k-1][QUO_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                work_reg[k] <= work_next;
                den_reg[k]  <= den_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sb_reg[k] <= '0;
            else if (en)
                sb_reg[k] <= sb_reg[k-1];
        end
    end

    assign quo    = work_reg[QUO_W];
    assign ovf    = ovf_reg[QUO_W];
    assign sb_out = sb_reg[QUO_W];

endmodule

`default_nettype wire

// File: sv/psal_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// psal_sqrt_pipe
// Pipelined integer square root, one result bit per stage, floor rounding,
// with a sideband that travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module psal_sqrt_pipe #(
    parameter int OUT_W = 24,
    parameter int SB_W  = 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic [2*OUT_W-1:0] radicand,
    input  wire logic [SB_W-1:0]    sb_in,
    output logic      [OUT_W-1:0]   root,
    output logic      [SB_W-1:0]    sb_out
);

    localparam int RW = 2 * OUT_W;

    logic [RW-1:0]    rem_reg [OUT_W];
    logic [OUT_W-1:0] res_reg [OUT_W];
    logic [SB_W-1:0]  sb_reg  [OUT_W];

    // stage k decides result bit OUT_W-1-k
    for (genvar k = 0; k < OUT_W; k++)
    begin : g_stage
        localparam int B = OUT_W - 1 - k;

        logic [RW-1:0]    rem_in;
        logic [OUT_W-1:0] res_in;
        logic [SB_W-1:0]  sb_cur;
        logic [RW-1:0]    delta;
        logic             take;
        logic [RW-1:0]    rem_next;
        logic [OUT_W-1:0] res_next;

        if (k == 0)
        begin : g_first
            assign rem_in = radicand;
            assign res_in = '0;
            assign sb_cur = sb_in;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign res_in = res_reg[k-1];
            assign sb_cur = sb_reg[k-1];
        end

        // (res + 2^B)^2 - res^2 = res * 2^(B+1) + 2^(2B)
        always_comb
        begin
            delta    = (RW'(res_in) << (B + 1)) | (RW'(1) << (2 * B));
            take     = (rem_in >= delta);
            rem_next = take ? (rem_in - delta) : rem_in;
            res_next = take ? (res_in | (OUT_W'(1) << B)) : res_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                res_reg[k] <= res_next;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sb_reg[k] <= '0;
            else if (en)
                sb_reg[k] <= sb_cur;
        end
    end

    assign root   = res_reg[OUT_W-1];
    assign sb_out = sb_reg[OUT_W-1];

endmodule

`default_nettype wire

// File: sv/psal_fifo.sv
// ----------------------------------------------------------------------------
// psal_fifo
// Short register queue between the front and back pipelines, with
// independent push and pop handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module psal_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic      [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage write
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// File: sv/psal_front.sv
// ----------------------------------------------------------------------------
// psal_front
// Accepts samples, clamps temperature, forms the first conductivity ratio
// and the rt polynomial, and prepares the temperature factor division.
// ----------------------------------------------------------------------------
`default_nettype none

module psal_front
    import psal_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [COND_W-1:0] in_cond,
    input  wire logic [TEMP_W-1:0] in_temp,
    input  wire logic [REF_W-1:0]  ref_cond,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output front_item_t            out_item
);

    localparam int RT_STAGES = 4;

    typedef struct packed {
        logic                     vld;
        logic signed [TEMP_W-1:0] t;
        logic [FNUM_W-1:0]        fnum;
        logic [FDEN_W-1:0]        fden;
        logic                     dneg;
    } fsb_t;

    typedef struct packed {
        logic [Q_W-1:0]           q;
        logic signed [TEMP_W-1:0] t;
        logic [FNUM_W-1:0]        fnum;
        logic [FDEN_W-1:0]        fden;
        logic                     dneg;
    } carry_t;

    logic                      en;
    logic signed [TEMP_W-1:0]  t_raw, t_clamp, d;
    logic [TEMP_W-2:0]         d_abs;
    logic signed [34:0]        kd;
    logic signed [35:0]        den_s;
    logic [FDEN_W-1:0]         fden;
    logic [FNUM_W-1:0]         fnum;
    logic [REF_W-1:0]          ref_eff;
    fsb_t                      sb_in, sb_out;
    logic [Q_W-1:0]            quo;
    logic                      ovf;
    logic [Q_W-1:0]            q_sel;

    logic signed [RT_ACC_W-1:0] acc_reg   [RT_STAGES];
    carry_t                     carry_reg [RT_STAGES];
    logic                       vld_reg   [RT_STAGES];

    logic signed [27:0]         rt_round;

    // whole front advances unless its last stage holds an item the queue refuses
    assign en        = !vld_reg[RT_STAGES-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[RT_STAGES-1];

    // temperature clamp and factor operands
    always_comb
    begin
        t_raw = $signed(in_temp);
        if (t_raw < T_LOW)
            t_clamp = T_LOW;
        else if (t_raw > T_HIGH)
            t_clamp = T_HIGH;
        else
            t_clamp = t_raw;
        d     = t_clamp - T_FIFTEEN;
        d_abs = d[TEMP_W-1] ? (TEMP_W-1)'(-d) : d[TEMP_W-2:0];
        kd    = $signed({1'b0, K_DEN}) * d;
        den_s = 36'sd4294967296 + 36'(kd);
        fden  = den_s[FDEN_W-1:0];
        fnum  = FNUM_W'({d_abs, 46'b0}) + FNUM_W'(fden[FDEN_W-1:1]);
    end

    assign ref_eff = (ref_cond == '0) ? REF_W'(1) : ref_cond;

    always_comb
    begin
        sb_in.vld  = in_valid;
        sb_in.t    = t_clamp;
        sb_in.fnum = fnum;
        sb_in.fden = fden;
        sb_in.dneg = d[TEMP_W-1];
    end

    // conductivity over reference, Q32
    psal_div_pipe #(
        .NUM_W (COND_W + 32),
        .DEN_W (REF_W),
        .QUO_W (Q_W),
        .SB_W  ($bits(fsb_t))
    ) u_div_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .num    ({in_cond, 32'b0}),
        .den    (ref_eff),
        .sb_in  (sb_in),
        .quo    (quo),
        .ovf    (ovf),
        .sb_out (sb_out)
    );

    assign q_sel = (ovf || (quo > Q_MAX)) ? Q_MAX : quo;

    // rt polynomial in Horner form, one product per stage
    for (genvar k = 0; k < RT_STAGES; k++)
    begin : g_rt
        logic signed [RT_ACC_W-1:0]        acc_in;
        logic signed [TEMP_W-1:0]          t_in;
        logic signed [RT_ACC_W+TEMP_W-1:0] prod;
        logic signed [RT_ACC_W+TEMP_W-1:0] prod_rnd;
        logic signed [RT_ACC_W-1:0]        acc_next;
        carry_t                            carry_in;
        logic                              vld_in;

        if (k == 0)
        begin : g_first
            assign acc_in        = C_RT[RT_STAGES];
            assign carry_in.q    = q_sel;
            assign carry_in.t    = sb_out.t;
            assign carry_in.fnum = sb_out.fnum;
            assign carry_in.fden = sb_out.fden;
            assign carry_in.dneg = sb_out.dneg;
            assign vld_in        = sb_out.vld;
        end
        else
        begin : g_next
            assign acc_in   = acc_reg[k-1];
            assign carry_in = carry_reg[k-1];
            assign vld_in   = vld_reg[k-1];
        end

        assign t_in = carry_in.t;

        always_comb
        begin
            prod     = acc_in * t_in;
            prod_rnd = (prod + 59'sd128) >>> 8;
            acc_next = C_RT[RT_STAGES-1-k] + RT_ACC_W'(prod_rnd);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[k]   <= acc_next;
                carry_reg[k] <= carry_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_in;
        end
    end

    // rt to Q24, at least one LSB
    always_comb
    begin
        rt_round       = 28'((acc_reg[RT_STAGES-1] + 44'sd32768) >>> 16);
        out_item.q     = carry_reg[RT_STAGES-1].q;
        out_item.rt    = (rt_round < 28'sd1) ? RT_W'(1) : rt_round[RT_W-1:0];
        out_item.fnum  = carry_reg[RT_STAGES-1].fnum;
        out_item.fden  = carry_reg[RT_STAGES-1].fden;
        out_item.dneg  = carry_reg[RT_STAGES-1].dneg;
    end

endmodule

`default_nettype wire

// File: sv/psal_back.sv
// ----------------------------------------------------------------------------
// psal_back
// Divides the ratio by rt, takes its square root, evaluates the a and b
// polynomials, applies the temperature factor and saturates the salinity.
// ----------------------------------------------------------------------------
`default_nettype none

module psal_back
    import psal_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire front_item_t in_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [SAL_W-1:0] out_sal
);

    localparam int P_STAGES = 5;
    localparam int DIV_Q_W  = RQ_W;

    logic                 en;
    logic [DIV_Q_W-1:0]   r_quo, f_quo;
    logic                 r_ovf, f_ovf;
    logic                 r_vld, f_dneg;
    logic [RQ_W-1:0]      r_sel;
    logic [DIV_Q_W-1:0]   fq;
    logic signed [F_W-1:0] f_val;
    logic [2*X_W-1:0]     radicand;
    logic [F_W:0]         sq_sb_in, sq_sb_out;
    logic [X_W-1:0]       x_root;

    logic signed [P_ACC_W-1:0] acc_a_reg [P_STAGES];
    logic signed [P_ACC_W-1:0] acc_b_reg [P_STAGES];
    logic [X_W-1:0]            x_reg     [P_STAGES];
    logic signed [F_W-1:0]     f_reg     [P_STAGES];
    logic                      vld_reg   [P_STAGES];

    logic signed [B_W+F_W-1:0] bf_reg;
    logic signed [P_ACC_W-1:0] a_reg;
    logic                      m_vld_reg;

    logic signed [49:0]        bf_rnd, s_pre, s_sh;
    logic [SAL_W-1:0]          sal_next;
    logic [SAL_W-1:0]          sal_reg;
    logic                      out_vld_reg;

    // back pipeline advances unless the output register holds an unread beat
    assign en        = !out_vld_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = out_vld_reg;
    assign out_sal   = sal_reg;

    // ratio over rt, Q32
    psal_div_pipe #(
        .NUM_W (Q_W + 24),
        .DEN_W (RT_W),
        .QUO_W (DIV_Q_W),
        .SB_W  (1)
    ) u_div_r (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .num    ({in_item.q, 24'b0}),
        .den    (in_item.rt),
        .sb_in  (in_valid),
        .quo    (r_quo),
        .ovf    (r_ovf),
        .sb_out (r_vld)
    );

    // temperature factor magnitude, rounded half away from zero
    psal_div_pipe #(
        .NUM_W (FNUM_W),
        .DEN_W (FDEN_W),
        .QUO_W (DIV_Q_W),
        .SB_W  (1)
    ) u_div_f (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .num    (in_item.fnum),
        .den    (in_item.fden),
        .sb_in  (in_item.dneg),
        .quo    (f_quo),
        .ovf    (f_ovf),
        .sb_out (f_dneg)
    );

    // clamp ratio, sign the factor
    always_comb
    begin
        r_sel    = (r_ovf || (r_quo > R_MAX)) ? R_MAX : r_quo;
        radicand = (2*X_W)'({r_sel, 8'b0});
        fq       = f_ovf ? '1 : f_quo;
        f_val    = f_dneg ? -$signed({1'b0, fq[F_W-2:0]}) : $signed({1'b0, fq[F_W-2:0]});
        sq_sb_in = {r_vld, f_val};
    end

    psal_sqrt_pipe #(
        .OUT_W (X_W),
        .SB_W  (F_W + 1)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .radicand (radicand),
        .sb_in    (sq_sb_in),
        .root     (x_root),
        .sb_out   (sq_sb_out)
    );

    // a and b polynomials in Horner form, side by side
    for (genvar k = 0; k < P_STAGES; k++)
    begin : g_poly
        logic signed [P_ACC_W-1:0]     a_in, b_in;
        logic [X_W-1:0]                x_in;
        logic signed [F_W-1:0]         f_in;
        logic                          vld_in;
        logic signed [X_W:0]           xs;
        logic signed [P_ACC_W+X_W:0]   pa, pb;
        logic signed [P_ACC_W+X_W:0]   pa_rnd, pb_rnd;
        logic signed [P_ACC_W-1:0]     a_next, b_next;

        if (k == 0)
        begin : g_first
            assign a_in   = C_A[P_STAGES];
            assign b_in   = C_B[P_STAGES];
            assign x_in   = x_root;
            assign f_in   = $signed(sq_sb_out[F_W-1:0]);
            assign vld_in = sq_sb_out[F_W];
        end
        else
        begin : g_next
            assign a_in   = acc_a_reg[k-1];
            assign b_in   = acc_b_reg[k-1];
            assign x_in   = x_reg[k-1];
            assign f_in   = f_reg[k-1];
            assign vld_in = vld_reg[k-1];
        end

        always_comb
        begin
            xs     = $signed({1'b0, x_in});
            pa     = a_in * xs;
            pb     = b_in * xs;
            pa_rnd = (pa + 66'sd524288) >>> 20;
            pb_rnd = (pb + 66'sd524288) >>> 20;
            a_next = C_A[P_STAGES-1-k] + P_ACC_W'(pa_rnd);
            b_next = C_B[P_STAGES-1-k] + P_ACC_W'(pb_rnd);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_a_reg[k] <= a_next;
                acc_b_reg[k] <= b_next;
                x_reg[k]     <= x_in;
                f_reg[k]     <= f_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_in;
        end
    end

    // b times factor, b held in its significant bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bf_reg <= $signed(acc_b_reg[P_STAGES-1][B_W-1:0]) * f_reg[P_STAGES-1];
            a_reg  <= acc_a_reg[P_STAGES-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_vld_reg <= 1'b0;
        else if (en)
            m_vld_reg <= vld_reg[P_STAGES-1];
    end

    // sum, round to Q16, saturate
    always_comb
    begin
        bf_rnd = 50'((bf_reg + 61'sd2097152) >>> 22);
        s_pre  = 50'(a_reg) + bf_rnd;
        s_sh   = (s_pre + 50'sd32) >>> 6;
        if (s_sh > 50'sd2147483647)
            sal_next = 32'h7FFF_FFFF;
        else if (s_sh < -50'sd2147483648)
            sal_next = 32'h8000_0000;
        else
            sal_next = s_sh[SAL_W-1:0];
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
            sal_reg <= sal_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= m_vld_reg;
    end

endmodule

`default_nettype wire

// File: sv/practical_salinity_from_conductivity_unit.sv
// ----------------------------------------------------------------------------
// practical_salinity_from_conductivity_unit
// Practical salinity (PSS-78, zero pressure) from conductivity and
// temperature, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries samples: conductivity (Q16, unsigned) and temperature
//   (Q8, signed). m_* returns one salinity beat (Q16, signed, saturated)
//   per sample, in order. cfg_* writes the reference conductivity; it is
//   always ready and should only be written while no samples are in flight.
//   Throughput is one sample per cycle while neither pipeline stalls. The
//   bit-per-stage dividers take 41 stages for the first ratio and 40 each
//   for the second ratio and the factor; the square root takes 24 stages.
//   A front pipeline (first ratio, rt) and a back pipeline (second ratio,
//   factor, root, polynomials) are coupled by a small queue; each stalls
//   on its own. When m_tready is low the back pipeline holds, the queue
//   fills, and then the front stops taking beats.
//   Reset clears all valid flags and loads the reference with 4291.4.
// ----------------------------------------------------------------------------
`default_nettype none

module practical_salinity_from_conductivity_unit
    import psal_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave side
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,    // [23:0] conductivity, [38:24] temperature
    // master side
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,    // [31:0] salinity
    // reference conductivity write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);

    logic [REF_W-1:0] ref_reg;
    logic             f_valid, f_ready;
    front_item_t      f_item;
    logic             b_valid, b_ready;
    front_item_t      b_item;

    // reference register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ref_reg <= REF_RESET;
        else if (cfg_valid && cfg_ready)
            ref_reg <= cfg_data;
    end

    // front
    psal_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cond   (s_tdata[COND_W-1:0]),
        .in_temp   (s_tdata[COND_W+TEMP_W-1:COND_W]),
        .ref_cond  (ref_reg),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    // queue between front and back
    psal_fifo #(
        .WIDTH ($bits(front_item_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_item),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_item)
    );

    // back
    psal_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid),
        .in_ready  (b_ready),
        .in_item   (b_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_sal   (m_tdata)
    );

endmodule

`default_nettype wire

// File: tb/salinity_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// salinity_checker
// Watches the sample, salinity and reference channels of the practical
// salinity unit, computes the salinity due for every accepted sample in
// fixed point and compares each returned beat against the oldest one due.
// ----------------------------------------------------------------------------
`default_nettype none

module salinity_checker
    import psal_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [39:0] s_tdata,    // [23:0] conductivity, [38:24] temperature
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,    // [31:0] salinity
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [31:0] cfg_data,
    output int               errors,
    output int               pending
);

    longint        rt_coef [5];
    longint        a_coef  [6];
    longint        b_coef  [6];
    logic [31:0]   ref_cond;
    logic [31:0]   salinity_due [$];

    // rounded n / d scaled by 2^s
    function automatic longint scaled(longint n, longint d, int s);
        return (n * (64'sd1 <<< s) + d / 2) / d;
    endfunction

    // round half up, then arithmetic shift
    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // degree-5 horner evaluation, q22 coefficients, x in q20
    function automatic longint horner5(bit use_b, longint x);
        longint acc;
        acc = use_b ? b_coef[5] : a_coef[5];
        for (int k = 4; k >= 0; k--)
            acc = (use_b ? b_coef[k] : a_coef[k]) + round_shift(acc * x, 20);
        return acc;
    endfunction

    function automatic logic [31:0] salinity_of(logic [23:0] cond,
                                                logic signed [14:0] temp,
                                                logic [31:0] refc);
        longint          t, rt, d, den, f, a, b, s;
        longint unsigned q, r, x, mag, fq, divisor;
        t = temp;
        if (t < T_LOW)
            t = T_LOW;
        if (t > T_HIGH)
            t = T_HIGH;
        // rt temperature polynomial, q40 then q24
        rt = rt_coef[4];
        for (int k = 3; k >= 0; k--)
            rt = rt_coef[k] + round_shift(rt * t, 8);
        rt = round_shift(rt, 16);
        if (rt < 1)
            rt = 1;
        // conductivity ratio and its root
        divisor = (refc == 0) ? 64'd1 : longint'(refc);
        q = (longint'(cond) << 32) / divisor;
        if (q > (64'd128 << 32))
            q = 64'd128 << 32;
        r = (q << 24) / longint'(rt);
        if (r > (64'd64 << 32))
            r = 64'd64 << 32;
        x = int_sqrt(r << 8);
        a = horner5(1'b0, longint'(x));
        b = horner5(1'b1, longint'(x));
        // temperature factor, rounded half away from zero
        d   = t - T_FIFTEEN;
        den = (64'sd1 <<< 32) + longint'(K_DEN) * d;
        mag = longint'(d < 0 ? -d : d) << 46;
        fq  = (mag + longint'(den) / 2) / longint'(den);
        f   = (d < 0) ? -longint'(fq) : longint'(fq);
        s = round_shift(a + round_shift(b * f, 22), 6);
        if (s > 64'sd2147483647)
            s = 64'sd2147483647;
        if (s < -64'sd2147483648)
            s = -64'sd2147483648;
        return s[31:0];
    endfunction

    initial
    begin
        rt_coef[0] = scaled(6766097, 10000000, 40);
        rt_coef[1] = scaled(200564, 10000000, 40);
        rt_coef[2] = scaled(1104259, 64'sd10000000000, 40);
        rt_coef[3] = -scaled(69698, 64'sd100000000000, 40);
        rt_coef[4] = scaled(10031, 64'sd10000000000000, 40);
        a_coef[0]  = scaled(8, 1000, 22);
        a_coef[1]  = -scaled(1692, 10000, 22);
        a_coef[2]  = scaled(253851, 10000, 22);
        a_coef[3]  = scaled(140941, 10000, 22);
        a_coef[4]  = -scaled(70261, 10000, 22);
        a_coef[5]  = scaled(27081, 10000, 22);
        b_coef[0]  = scaled(5, 10000, 22);
        b_coef[1]  = -scaled(56, 10000, 22);
        b_coef[2]  = -scaled(66, 10000, 22);
        b_coef[3]  = -scaled(375, 10000, 22);
        b_coef[4]  = scaled(636, 10000, 22);
        b_coef[5]  = -scaled(144, 10000, 22);
    end

    assign pending = salinity_due.size();

    // track reference, queue predictions, compare returned beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_cond = REF_RESET;
            errors   = 0;
            salinity_due.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (salinity_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected salinity beat %h", $realtime, m_tdata);
                end
                else
                begin
                    logic [31:0] want;
                    want = salinity_due.pop_front();
                    if (want !== m_tdata)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: salinity expected %h got %h",
                                     $realtime, want, m_tdata);
                    end
                end
            end
            if (s_tvalid && s_tready)
                salinity_due.push_back(salinity_of(s_tdata[23:0], s_tdata[38:24], ref_cond));
            if (cfg_valid && cfg_ready)
                ref_cond = cfg_data;
        end
    end

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives samples and reference writes into the practical salinity unit under
// random back pressure and gaps; the checker predicts and compares results.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import psal_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // [23:0] conductivity, [38:24] temperature
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [31:0] salinity
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    int          errors;
    int          pending;
    int          send_idle;
    int          recv_idle;
    int          hold_left;

    practical_salinity_from_conductivity_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    salinity_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #10ms;
        $display("practical_salinity_from_conductivity_unit test failed");
        $finish;
    end

    // receiver: random stalls plus requested hold-off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // one sample beat, with random gaps before it
    task automatic send_sample(logic [23:0] cond, logic [14:0] temp);
        while ($urandom_range(99) < send_idle)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, temp, cond};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
    endtask

    // reference write with the pipeline empty
    task automatic write_reference(logic [31:0] value);
        wait_drained();
        repeat (130) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_sample();
        logic [23:0] cond;
        logic [14:0] temp;
        case ($urandom_range(3))
            0:       cond = 24'($urandom_range(24'hFFFFFF));
            1:       cond = 24'($urandom_range(4095));
            default: cond = 24'($urandom_range(524288));
        endcase
        if ($urandom_range(4) == 0)
            temp = 15'($urandom_range(15'h7FFF));
        else
            temp = 15'($urandom_range(15360) - 2560);
        send_sample(cond, temp);
    endtask

    initial
    begin
        logic [31:0] refs [6];
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        send_idle = 0;
        recv_idle = 0;
        hold_left = 0;
        rst_n     = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, clamped temperatures, zero factor, ratio near 0.001
        send_sample(24'd0, 15'd0);
        send_sample(24'hFFFFFF, 15'd0);
        send_sample(24'd281241, T_FIFTEEN);
        send_sample(24'd281241, T_LOW);
        send_sample(24'd281241, T_HIGH);
        send_sample(24'd281241, 15'h4000);
        send_sample(24'd281241, 15'h3FFF);
        send_sample(24'd281241, 15'(T_LOW - 1));
        send_sample(24'd281241, 15'(T_HIGH + 1));
        send_sample(24'hFFFFFF, 15'h4000);
        send_sample(24'hFFFFFF, 15'h3FFF);
        send_sample(24'd1, T_HIGH);
        send_sample(24'h800000, T_LOW);
        send_sample(24'd140620, 15'd5120);
        send_sample(24'd562482, 15'd1280);
        send_sample(24'h555555, 15'h2AAA);
        send_sample(24'hAAAAAA, 15'h5555);
        send_sample(24'd65536, 15'h7FFF);

        refs[0] = 32'd1;
        refs[1] = 32'hFFFFFFFF;
        refs[2] = $urandom;
        refs[3] = 32'd65536 + $urandom_range(32'h1000000);
        refs[4] = REF_RESET;
        refs[5] = 32'd200000000 + $urandom_range(100000000);
        for (int seg = 0; seg < 6; seg++)
        begin
            write_reference(refs[seg]);
            send_idle = (seg < 2) ? 22 : (seg < 4) ? 57 : 0;
            recv_idle = (seg < 2) ? 57 : (seg < 4) ? 22 : 0;
            if (seg == 4)
                hold_left = 400;
            for (int n = 0; n < 190; n++)
            begin
                if (seg == 5 && n == 95)
                    wait_drained();
                random_sample();
            end
        end

        wait_drained();
        repeat (130) @(posedge clk);
        if (errors == 0)
            $display("practical_salinity_from_conductivity_unit test passed");
        else
            $display("practical_salinity_from_conductivity_unit test failed");
        $finish;
    end

endmodule

`default_nettype wire
